// ===== rtl/core/teai_pkg.sv =====
// shared types, widths and helper functions for the triangle edge axis intercept block
package teai_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;

  // coordinate difference, divider and product widths
  localparam int DW  = COORD_BITS + 1;
  localparam int QW  = DW + FRAC_BITS;
  localparam int QLO = QW / 2;
  localparam int QHI = QW - QLO;
  localparam int PRW = DW + QW;
  localparam int MW  = PRW - FRAC_BITS;
  localparam int PW  = COORD_BITS + 2;
  localparam int SW  = COORD_BITS + 4;

  // lane pipeline stages: input register, one divider stage per quotient bit, three math stages
  localparam int LANE_LAT = QW + 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [2:0][COORD_BITS-1:0] vec_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
  } pt_t;

  typedef struct packed {
    coord_t xcut_dx;
    coord_t xcut_dy;
    coord_t xcut_dz;
    coord_t ycut_dx;
    coord_t ycut_dy;
    coord_t ycut_dz;
    coord_t zcut_dx;
    coord_t zcut_dy;
    coord_t zcut_dz;
    logic   missing_slope;
  } cut_t;

  // per-lane data that rides alongside the quotient
  typedef struct packed {
    logic                       interp;
    logic [2:0]                 dneg;
    logic [2:0][DW-1:0]         cp;
    logic [2:0][DW-1:0]         dm;
  } side_t;

  // magnitude of a signed difference
  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] n;
    n = -v;
    return v[DW-1] ? DW'(n) : DW'(v);
  endfunction

  // saturate a wide signed value to the coordinate range
  function automatic logic [COORD_BITS-1:0] clampc(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = (SW'(1) << (COORD_BITS - 1)) - SW'(1);
    lo = -(SW'(1) << (COORD_BITS - 1));
    if (v > hi) begin
      return hi[COORD_BITS-1:0];
    end else if (v < lo) begin
      return lo[COORD_BITS-1:0];
    end
    return v[COORD_BITS-1:0];
  endfunction

endpackage

// ===== rtl/core/teai_divider.sv =====
// pipelined restoring divider, one quotient bit per stage, side data carried along
module teai_divider import teai_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  input  side_t         side_in,
  output logic [QW-1:0] quo,
  output side_t         side_out
);

  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [QW-1:0] dvd_r  [QW];
  logic [DW-1:0] den_r  [QW];
  side_t         side_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW-1:0] rem_i;
    logic [QW-1:0] quo_i;
    logic [QW-1:0] dvd_i;
    logic [DW-1:0] den_i;
    side_t         side_i;
    logic [DW:0]   trial;
    logic [DW:0]   sub;

    // stage input: first stage takes the operands, later ones the previous stage
    if (i == 0) begin : g_first
      assign rem_i  = '0;
      assign quo_i  = '0;
      assign dvd_i  = {num, {FRAC_BITS{1'b0}}};
      assign den_i  = den;
      assign side_i = side_in;
    end else begin : g_next
      assign rem_i  = rem_r[i-1];
      assign quo_i  = quo_r[i-1];
      assign dvd_i  = dvd_r[i-1];
      assign den_i  = den_r[i-1];
      assign side_i = side_r[i-1];
    end

    // shift in the next dividend bit and try a subtract
    assign trial = {rem_i, dvd_i[QW-1]};
    assign sub   = trial - {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= {1'b0, den_i}) begin
          rem_r[i] <= sub[DW-1:0];
          quo_r[i] <= {quo_i[QW-2:0], 1'b1};
        end else begin
          rem_r[i] <= trial[DW-1:0];
          quo_r[i] <= {quo_i[QW-2:0], 1'b0};
        end
        dvd_r[i]  <= {dvd_i[QW-2:0], 1'b0};
        den_r[i]  <= den_i;
        side_r[i] <= side_i;
      end
    end
  end

  assign quo      = quo_r[QW-1];
  assign side_out = side_r[QW-1];

endmodule

// ===== rtl/core/teai_lane.sv =====
// one axis lane: case selection, ratio divide, scaled offset and saturation
module teai_lane import teai_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic [1:0] axis,
  input  pt_t        pt,
  output vec_t       res
);

  coord_t a [3];
  coord_t b [3];
  coord_t c [3];
  coord_t ak, bk, ck;
  logic signed [DW-1:0] d;
  logic from_a, from_b;
  coord_t p [3];
  coord_t q [3];
  coord_t t [3];
  logic signed [DW-1:0] num_s, den_s;
  logic [DW-1:0] num_c, den_c;
  side_t side_c;

  logic [DW-1:0] num_r, den_r;
  side_t side_r;

  logic [QW-1:0] quo;
  side_t side_d;

  logic [2:0][DW+QHI-1:0] phi;
  logic [2:0][DW+QLO-1:0] plo;
  side_t side_m1;

  logic [2:0][PW-1:0] m;
  side_t side_m2;

  assign a = '{pt.a_x, pt.a_y, pt.a_z};
  assign b = '{pt.b_x, pt.b_y, pt.b_z};
  assign c = '{pt.c_x, pt.c_y, pt.c_z};

  // pick the interpolation base for this axis
  always_comb begin
    ak = a[axis];
    bk = b[axis];
    ck = c[axis];
    d  = DW'(bk) - DW'(ak);
    from_a = (ck > ak && ck < bk) || (ck < ak && ck > bk) ||
             (d > 0 && ck > bk) || (d < 0 && ck < bk);
    from_b = (d > 0 && ck < ak) || (d < 0 && ck > ak);
    for (int j = 0; j < 3; j++) begin
      if (from_b) begin
        p[j] = b[j];
        q[j] = a[j];
        t[j] = c[j];
      end else if (from_a || ck == ak) begin
        p[j] = a[j];
        q[j] = b[j];
        t[j] = c[j];
      end else if (ck == bk) begin
        p[j] = b[j];
        q[j] = a[j];
        t[j] = c[j];
      end else begin
        p[j] = a[j];
        q[j] = b[j];
        t[j] = b[j];
      end
    end
    num_s = DW'(ck) - DW'(p[axis]);
    den_s = DW'(q[axis]) - DW'(p[axis]);
    num_c = mag(num_s);
    den_c = (den_s == '0) ? DW'(1) : mag(den_s);
    side_c.interp = from_a || from_b;
    for (int j = 0; j < 3; j++) begin
      logic signed [DW-1:0] dl;
      dl = DW'(q[j]) - DW'(p[j]);
      side_c.cp[j]   = DW'(t[j]) - DW'(p[j]);
      side_c.dneg[j] = dl[DW-1];
      side_c.dm[j]   = mag(dl);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= num_c;
      den_r  <= den_c;
      side_r <= side_c;
    end
  end

  teai_divider u_div (
    .clk      (clk),
    .en       (en),
    .num      (num_r),
    .den      (den_r),
    .side_in  (side_r),
    .quo      (quo),
    .side_out (side_d)
  );

  // partial products of offset magnitude and ratio
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        phi[j] <= side_d.dm[j] * quo[QW-1:QLO];
        plo[j] <= side_d.dm[j] * quo[QLO-1:0];
      end
      side_m1 <= side_d;
    end
  end

  // combine partial products, drop fraction, saturate
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        logic [PRW-1:0] full;
        logic [MW-1:0]  mr;
        full = {phi[j], {QLO{1'b0}}} + PRW'(plo[j]);
        mr   = full[PRW-1:FRAC_BITS];
        if (mr > (MW'(1) << (COORD_BITS + 1))) begin
          m[j] <= PW'(1) << (COORD_BITS + 1);
        end else begin
          m[j] <= mr[PW-1:0];
        end
      end
      side_m2 <= side_m1;
    end
  end

  // final vector component with saturation
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        logic signed [SW-1:0] cpx;
        logic signed [SW-1:0] mx;
        cpx = SW'(signed'(side_m2.cp[j]));
        mx  = SW'({1'b0, m[j]});
        if (!side_m2.interp) begin
          res[j] <= clampc(cpx);
        end else if (axis == 2'(j)) begin
          res[j] <= '0;
        end else if (side_m2.dneg[j]) begin
          res[j] <= clampc(cpx + mx);
        end else begin
          res[j] <= clampc(cpx - mx);
        end
      end
    end
  end

endmodule

// ===== rtl/core/teai_merge.sv =====
// merges the three lane vectors into the result transaction and flags zero vectors
module teai_merge import teai_pkg::*; (
  input  logic clk,
  input  logic en,
  input  vec_t xv,
  input  vec_t yv,
  input  vec_t zv,
  output cut_t cut
);

  logic missing;

  // any all-zero vector raises the flag
  assign missing = (xv == '0) || (yv == '0) || (zv == '0);

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      cut.xcut_dx       <= xv[0];
      cut.xcut_dy       <= xv[1];
      cut.xcut_dz       <= xv[2];
      cut.ycut_dx       <= yv[0];
      cut.ycut_dy       <= yv[1];
      cut.ycut_dz       <= yv[2];
      cut.zcut_dx       <= zv[0];
      cut.zcut_dy       <= zv[1];
      cut.zcut_dz       <= zv[2];
      cut.missing_slope <= missing;
    end
  end

endmodule

// ===== rtl/core/triangle_edge_axis_intercepts.sv =====
// top level: three axis lanes, merge stage and pipeline valid control
//
//  channel  | valid      | ready      | payload
//  ---------+------------+------------+----------------------------
//  input    | pt_valid   | pt_ready   | pt  (edge a, b and point c)
//  output   | cut_valid  | cut_ready  | cut (three vectors, flag)
//
// one transaction per cycle unless the output stalls; the pipeline consists of the
// 49-stage divider in each lane plus input, two multiply stages, a saturate stage
// and the output register. the whole pipeline holds while a result waits and
// cut_ready is low; pt_ready follows that. reset clears only the valid bits.
module triangle_edge_axis_intercepts import teai_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic pt_valid,
  output logic pt_ready,
  input  pt_t  pt,
  output logic cut_valid,
  input  logic cut_ready,
  output cut_t cut
);

  localparam int NV = LANE_LAT + 1;

  logic          adv;
  logic [NV-1:0] vld;
  vec_t          xv, yv, zv;

  // advance when the output slot is free or being taken
  assign adv       = !vld[NV-1] || cut_ready;
  assign pt_ready  = adv;
  assign cut_valid = vld[NV-1];

  // valid tracking along the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NV-2:0], pt_valid};
    end
  end

  teai_lane u_lane_x (.clk(clk), .en(adv), .axis(2'd0), .pt(pt), .res(xv));
  teai_lane u_lane_y (.clk(clk), .en(adv), .axis(2'd1), .pt(pt), .res(yv));
  teai_lane u_lane_z (.clk(clk), .en(adv), .axis(2'd2), .pt(pt), .res(zv));

  teai_merge u_merge (
    .clk (clk),
    .en  (adv),
    .xv  (xv),
    .yv  (yv),
    .zv  (zv),
    .cut (cut)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the triangle edge axis intercept block: directed table, random edges, scoreboard
module tb_top import teai_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint trio_t [3];

  localparam longint CMAX_V = (64'sd1 <<< (COORD_BITS - 1)) - 1;
  localparam longint CMIN_V = -(64'sd1 <<< (COORD_BITS - 1));
  localparam longint unsigned PLIM_V = 64'd1 << (COORD_BITS + 1);
  localparam int DRAIN_CYC = LANE_LAT + 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pt_valid = 1'b0;
  logic pt_ready;
  pt_t  pt = '0;
  logic cut_valid;
  logic cut_ready = 1'b0;
  cut_t cut;

  cut_t cut_expected_q [$];
  int   fail_cnt = 0;
  int   cut_cnt = 0;
  int   send_idle_pct = 10;
  int   recv_idle_pct = 88;
  bit   hold_req = 1'b0;
  bit   dir_typed = 1'b0;
  cut_t dir_result = '0;

  triangle_edge_axis_intercepts u_top (
    .clk(clk), .rst(rst), .pt_valid(pt_valid), .pt_ready(pt_ready), .pt(pt),
    .cut_valid(cut_valid), .cut_ready(cut_ready), .cut(cut)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor helpers
  function automatic longint clamp_coord(input longint v);
    if (v > CMAX_V) return CMAX_V;
    if (v < CMIN_V) return CMIN_V;
    return v;
  endfunction

  function automatic longint unsigned abs64(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // dm times (ip + fp/2^FRAC), truncated, saturated at the product limit
  function automatic longint unsigned scaled_mag(input longint unsigned dm,
      input longint unsigned ip, input longint unsigned fp);
    longint unsigned whole, part, m;
    if (ip != 0 && dm > PLIM_V / ip) return PLIM_V;
    whole = dm * ip;
    part = (((dm >> 32) * fp) << (32 - FRAC_BITS)) + (((dm & 64'hFFFF_FFFF) * fp) >> FRAC_BITS);
    m = whole + part;
    return (m > PLIM_V) ? PLIM_V : m;
  endfunction

  // point on line base->other matching c on axis k, returns c minus that point
  function automatic trio_t lerp_cut(input trio_t p, input trio_t q, input trio_t c, input int k);
    trio_t r;
    longint unsigned num, den, ip, rem, fp;
    longint delta, m;
    num = abs64(c[k] - p[k]);
    den = abs64(q[k] - p[k]);
    if (den == 0) den = 1;
    ip = num / den;
    rem = num % den;
    fp = 0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      rem = rem << 1;
      fp = fp << 1;
      if (rem >= den) begin
        rem = rem - den;
        fp = fp | 1;
      end
    end
    for (int j = 0; j < 3; j++) begin
      if (j == k) begin
        r[j] = 0;
      end else begin
        delta = q[j] - p[j];
        m = longint'(scaled_mag(abs64(delta), ip, fp));
        if (delta < 0) m = -m;
        r[j] = clamp_coord(c[j] - p[j] - m);
      end
    end
    return r;
  endfunction

  function automatic trio_t vec_diff(input trio_t from, input trio_t to);
    trio_t r;
    for (int j = 0; j < 3; j++) r[j] = clamp_coord(to[j] - from[j]);
    return r;
  endfunction

  // expected intercept vectors and flag for one edge
  function automatic cut_t predict_cut(input pt_t p);
    trio_t a, b, c, r;
    longint ak, bk, ck, d;
    logic [8:0][COORD_BITS-1:0] comp;
    logic miss;
    cut_t o;
    a = '{longint'(p.a_x), longint'(p.a_y), longint'(p.a_z)};
    b = '{longint'(p.b_x), longint'(p.b_y), longint'(p.b_z)};
    c = '{longint'(p.c_x), longint'(p.c_y), longint'(p.c_z)};
    miss = 1'b0;
    for (int k = 0; k < 3; k++) begin
      ak = a[k]; bk = b[k]; ck = c[k]; d = bk - ak;
      if ((ck > ak && ck < bk) || (ck < ak && ck > bk) || (d > 0 && ck > bk) ||
          (d < 0 && ck < bk)) begin
        r = lerp_cut(a, b, c, k);
      end else if ((d > 0 && ck < ak) || (d < 0 && ck > ak)) begin
        r = lerp_cut(b, a, c, k);
      end else if (ck == ak) begin
        r = vec_diff(a, c);
      end else if (ck == bk) begin
        r = vec_diff(b, c);
      end else begin
        r = vec_diff(a, b);
      end
      if (r[0] == 0 && r[1] == 0 && r[2] == 0) miss = 1'b1;
      for (int j = 0; j < 3; j++) comp[8 - (k * 3 + j)] = r[j][COORD_BITS-1:0];
    end
    o = {comp, miss};
    return o;
  endfunction

  // scoreboard: push on input transaction, compare on output transaction
  always @(posedge clk) begin
    cut_t e;
    string names [9];
    names = '{"xcut_dx", "xcut_dy", "xcut_dz", "ycut_dx", "ycut_dy", "ycut_dz",
              "zcut_dx", "zcut_dy", "zcut_dz"};
    if (!rst && pt_valid && pt_ready) begin
      cut_expected_q.push_back(dir_typed ? dir_result : predict_cut(pt));
    end
    if (!rst && cut_valid && cut_ready) begin
      cut_cnt++;
      if (cut_expected_q.size() == 0) begin
        $error("result with nothing expected");
        fail_cnt++;
      end else begin
        e = cut_expected_q.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (e[1 + COORD_BITS * (8 - i) +: COORD_BITS] !==
              cut[1 + COORD_BITS * (8 - i) +: COORD_BITS]) begin
            $error("%s expected %h actual %h", names[i],
                   e[1 + COORD_BITS * (8 - i) +: COORD_BITS],
                   cut[1 + COORD_BITS * (8 - i) +: COORD_BITS]);
            fail_cnt++;
          end
        end
        if (e.missing_slope !== cut.missing_slope) begin
          $error("missing_slope expected %b actual %b", e.missing_slope, cut.missing_slope);
          fail_cnt++;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    int hold_cnt;
    if (hold_req) begin
      hold_req <= 1'b0;
      cut_ready <= 1'b0;
      for (hold_cnt = 0; hold_cnt < 300; hold_cnt++) @(posedge clk);
    end
    cut_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // one input transaction, then an optional gap
  task automatic send_edge(input pt_t p);
    int gap;
    pt <= p;
    pt_valid <= 1'b1;
    do @(posedge clk); while (!pt_ready);
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      pt_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // coordinate mix: extremes, small values, full range
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0: return coord_t'(CMAX_V);
      1: return coord_t'(CMIN_V);
      2: return '0;
      3, 4: return coord_t'($urandom_range(0, 32'h0010_0000)) - coord_t'(32'h0008_0000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic pt_t rand_edge();
    pt_t p;
    coord_t a [3], b [3], c [3];
    for (int k = 0; k < 3; k++) begin
      a[k] = rand_coord();
      b[k] = rand_coord();
      c[k] = rand_coord();
      // force endpoint matches and flat axes now and then
      case ($urandom_range(0, 9))
        0: c[k] = a[k];
        1: c[k] = b[k];
        2: b[k] = a[k];
        3: b[k] = a[k] + coord_t'($urandom_range(0, 2)) - coord_t'(1);
        default: ;
      endcase
    end
    p = '{a[0], a[1], a[2], b[0], b[1], b[2], c[0], c[1], c[2]};
    return p;
  endfunction

  typedef struct {
    pt_t  stim;
    bit   typed;
    cut_t result;
  } dir_row_t;

  localparam coord_t MX = coord_t'(CMAX_V);
  localparam coord_t MN = coord_t'(CMIN_V);
  localparam coord_t ONE = coord_t'(32'h0001_0000);

  // stimulus
  initial begin
    dir_row_t rows [$];
    cut_t zero_miss;
    zero_miss = '0;
    zero_miss.missing_slope = 1'b1;
    // all at origin
    rows.push_back('{pt_t'('0), 1'b1, zero_miss});
    // c equal to a at max, b at min
    rows.push_back('{'{MX, MX, MX, MN, MN, MN, MX, MX, MX}, 1'b1, zero_miss});
    // c equal to a at min, b at max
    rows.push_back('{'{MN, MN, MN, MX, MX, MX, MN, MN, MN}, 1'b1, zero_miss});
    // flat on every axis, c differs
    rows.push_back('{'{'0, '0, '0, '0, '0, '0, MN, MX, MN}, 1'b1, zero_miss});
    rows.push_back('{'{'0, '0, '0, MX, MX, MX, MX, MX, MX}, 1'b0, '0});
    // c strictly between a and b
    rows.push_back('{'{'0, '0, '0, 4*ONE, 8*ONE, -2*ONE, 2*ONE, ONE, -ONE}, 1'b0, '0});
    // c beyond b on x and y, before a on z
    rows.push_back('{'{'0, '0, '0, ONE, 3*ONE, 5*ONE, 7*ONE, 9*ONE, -4*ONE}, 1'b0, '0});
    // c before a
    rows.push_back('{'{ONE, ONE, ONE, 2*ONE, 3*ONE, 4*ONE, -5*ONE, -ONE, '0}, 1'b0, '0});
    // descending edge
    rows.push_back('{'{5*ONE, 5*ONE, 5*ONE, -ONE, -2*ONE, -3*ONE, '0, 6*ONE, -9*ONE},
                     1'b0, '0});
    // huge ratio, results saturate
    rows.push_back('{'{'0, '0, '0, coord_t'(1), coord_t'(1), coord_t'(1), MX, MN, MX},
                     1'b0, '0});
    rows.push_back('{'{MN, '0, MX, MX, coord_t'(1), MN, '0, MN, coord_t'(5)}, 1'b0, '0});
    // c equal to b on one axis
    rows.push_back('{'{'0, ONE, '0, 3*ONE, 2*ONE, ONE, 3*ONE, 7*ONE, -ONE}, 1'b0, '0});
    rows.push_back('{'{MX, MN, MX, MN, MX, MN, MX, MX, MN}, 1'b0, '0});
    rows.push_back('{'{coord_t'(-1), coord_t'(-1), coord_t'(-1), '0, '0, '0,
                       coord_t'(3), coord_t'(-7), coord_t'(1)}, 1'b0, '0});

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table; typed rows supply the expected transaction themselves
    foreach (rows[i]) begin
      dir_typed <= rows[i].typed;
      dir_result <= rows[i].result;
      send_edge(rows[i].stim);
    end
    dir_typed <= 1'b0;

    // phase one: sender mostly busy, receiver mostly stalled, with one long hold-off
    for (int n = 0; n < 430; n++) begin
      if (n == 100) hold_req = 1'b1;
      send_edge(rand_edge());
    end
    send_idle_pct = 88;
    recv_idle_pct = 10;
    for (int n = 0; n < 430; n++) begin
      // pause until the pipeline has drained
      if (n == 200) begin
        pt_valid <= 1'b0;
        wait (cut_expected_q.size() == 0);
        @(posedge clk);
      end
      send_edge(rand_edge());
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int n = 0; n < 440; n++) send_edge(rand_edge());
    pt_valid <= 1'b0;

    wait (cut_expected_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    $display("covered %0d edges: endpoints, flat axes, saturation, both directions", cut_cnt);
    $display("idle mixes on both channels, long output hold-off and full drain pause");
    if (fail_cnt == 0 && cut_expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
